FILE: src/nelder_mead_rosenbrock_2d_defines.svh
// Assertion macros shared by the simplex search RTL.
// Bodies refer to clk and rst_n of the module that expands them.
`ifndef NELDER_MEAD_ROSENBROCK_2D_DEFINES_SVH
`define NELDER_MEAD_ROSENBROCK_2D_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define NMR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define NMR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/nmr_pkg.sv
// Shared constants and types for the 2D simplex search on the Rosenbrock function.
// No dependencies.
package nmr_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int VALUE_WIDTH_DEF = 63;
    localparam int FRAC            = 24;
    localparam int MUL_W           = 64;
    localparam int HALF_W          = MUL_W / 2;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int SQ_W            = 64;
    localparam int ITER_W          = 16;
    localparam int LIMIT_W         = 32;
    localparam int CFG_DATA_W      = 32;

    localparam logic [ITER_W-1:0]  MAX_ITER_RESET    = 16'd1000;
    localparam logic [LIMIT_W-1:0] SPREAD_LIM_RESET  = '0;
    localparam logic [MUL_W-1:0]   HUNDRED_Q24       = 64'd100 << FRAC;

    typedef enum logic
    {
        CFG_MAX_ITER     = 1'b0,
        CFG_SPREAD_LIMIT = 1'b1
    } cfg_idx_t;

    // Request to the shared multiplier
    typedef struct packed
    {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    // Status and product from the shared multiplier
    typedef struct packed
    {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

endpackage

FILE: src/nelder_mead_rosenbrock_2d.sv
// Nelder-Mead simplex search in 2D on 100(y-x^2)^2+(1-x)^2, Q8.24 fixed point.
// Each evaluation is four multiplies on the shared 64x64 multiplier; a search
// starts after the marked last vertex and ends with 3 results.
// Throughput: one vertex per cycle while loading; no input during a search.
// Reset: asynchronous, active low; clears control and counters, restores configuration defaults.
`include "nelder_mead_rosenbrock_2d_defines.svh"
module nelder_mead_rosenbrock_2d
    import nmr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int IN_W  = ((2 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_WIDTH + VALUE_WIDTH + ITER_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // vertex requests
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,  // coord_x, coord_y
    input  logic                  s_axis_tlast,  // last_vertex
    // result requests
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,  // out_x, out_y, out_value, passes_done
    output logic                  m_axis_tlast   // last_result
);

    localparam int CW = COORD_WIDTH;
    localparam int VW = VALUE_WIDTH;
    localparam int EW = CW + 2;
    localparam logic [VW-1:0] VMAX = {VW{1'b1}};
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [EW-1:0] ONE_E = {{(EW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

    typedef enum logic [15:0]
    {
        ST_IDLE       = 16'h0001,
        ST_EVAL       = 16'h0002,
        ST_ROS_ISSUE  = 16'h0004,
        ST_ROS_WAIT   = 16'h0008,
        ST_EVAL_DONE  = 16'h0010,
        ST_SORT       = 16'h0020,
        ST_SPR_ISSUE  = 16'h0040,
        ST_SPR_WAIT   = 16'h0080,
        ST_CENT       = 16'h0100,
        ST_REFL       = 16'h0200,
        ST_REFL_DONE  = 16'h0400,
        ST_EXP_DONE   = 16'h0800,
        ST_CONTR      = 16'h1000,
        ST_CONTR_DONE = 16'h2000,
        ST_PASS_END   = 16'h4000,
        ST_OUT        = 16'h8000
    } state_t;

    // halve a sum, rounding toward minus infinity
    function automatic logic signed [CW-1:0] halfsum(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        return s[CW:1];
    endfunction

    // 2p - c, saturated to the coordinate range
    function automatic logic signed [CW-1:0] reflect(input logic signed [CW-1:0] p,
                                                     input logic signed [CW-1:0] c);
        logic signed [EW-1:0] t;
        t = {p[CW-1], p, 1'b0} - {{2{c[CW-1]}}, c};
        if ((t[EW-1:CW-1] != '0) && (t[EW-1:CW-1] != '1))
        begin
            return t[EW-1] ? CMIN : CMAX;
        end
        return t[CW-1:0];
    endfunction

    // control state
    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [1:0]         loaded_reg, loaded_next;
    logic [ITER_W-1:0]  pass_reg, pass_next;
    logic [ITER_W-1:0]  max_iter_reg;
    logic [LIMIT_W-1:0] spread_lim_reg;
    logic [1:0]         vidx_reg, vidx_next;
    logic [1:0]         sidx_reg, sidx_next;
    logic [1:0]         sp_reg, sp_next;
    logic [1:0]         rstep_reg, rstep_next;
    logic [1:0]         k_reg, k_next;
    logic               fin_reg, fin_next;

    // datapath
    logic signed [CW-1:0] vx_reg [3];
    logic signed [CW-1:0] vy_reg [3];
    logic [VW-1:0]        v_reg  [3];
    logic signed [CW-1:0] rx_reg, ry_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [CW-1:0] sx_reg, sy_reg;
    logic signed [CW-1:0] ex_reg, ey_reg;
    logic [VW-1:0]        x2_reg, t1_reg, rres_reg, ys_reg;
    logic [SQ_W-1:0]      sum_reg;
    logic                 dbig_reg;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    logic                 in_acc, out_acc;
    logic [ITER_W-1:0]    cap;
    logic [VW-1:0]        mq;
    logic [CW-1:0]        rmag_x;
    logic signed [EW-1:0] om;
    logic [EW-1:0]        om_mag;
    logic [VW:0]          yz, x2z, dsum;
    logic [VW-1:0]        dval;
    logic [VW:0]          rsum;
    logic [VW-1:0]        sdiff;
    logic                 dbig;
    logic [SQ_W-1:0]      sq;
    logic [SQ_W:0]        ssum;
    logic [LIMIT_W+2:0]   thr;
    logic                 settled;
    logic signed [CW-1:0] in_x, in_y;
    logic signed [CW-1:0] o_x, o_y;
    logic [VW-1:0]        o_v;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign cap     = (max_iter_reg == '0) ? ITER_W'(1) : max_iter_reg;
    assign in_x    = s_axis_tdata[CW-1:0];
    assign in_y    = s_axis_tdata[2*CW-1:CW];

    // saturated Q.24 product
    assign mq = (mul_rsp.prod[PROD_W-1:FRAC+VW] != '0) ? VMAX
              : mul_rsp.prod[FRAC+VW-1:FRAC];

    // evaluation operands
    always_comb
    begin
        rmag_x = rx_reg[CW-1] ? (~rx_reg + CW'(1)) : rx_reg;
        om     = ONE_E - {{2{rx_reg[CW-1]}}, rx_reg};
        om_mag = om[EW-1] ? (~om + EW'(1)) : om;
        yz     = {{(VW+1-CW){1'b0}}, (ry_reg[CW-1] ? (~ry_reg + CW'(1)) : ry_reg)};
        x2z    = {1'b0, x2_reg};
        dsum   = x2z + yz;
        if (!ry_reg[CW-1])
        begin
            dval = (yz >= x2z) ? VW'(yz - x2z) : VW'(x2z - yz);
        end
        else
        begin
            dval = dsum[VW] ? VMAX : dsum[VW-1:0];
        end
        rsum = {1'b0, t1_reg} + {1'b0, mq};
    end

    // spread terms
    always_comb
    begin
        unique case (sp_reg)
            2'd0:    sdiff = v_reg[1] - v_reg[0];
            2'd1:    sdiff = v_reg[2] - v_reg[1];
            default: sdiff = v_reg[2] - v_reg[0];
        endcase
        dbig    = (sdiff[VW-1:32] != '0);
        sq      = dbig_reg ? {SQ_W{1'b1}} : mul_rsp.prod[SQ_W-1:0];
        ssum    = {1'b0, sum_reg} + {1'b0, sq};
        thr     = {1'b0, spread_lim_reg, 2'b0} + {2'b0, spread_lim_reg, 1'b0}
                + (LIMIT_W+3)'(5);
        settled = (sum_reg <= {{(SQ_W-LIMIT_W-3){1'b0}}, thr});
    end

    // multiplier requests
    always_comb
    begin
        mul_req.start = (state_reg == ST_ROS_ISSUE) || (state_reg == ST_SPR_ISSUE);
        mul_req.a     = '0;
        mul_req.b     = '0;
        if (state_reg == ST_SPR_ISSUE)
        begin
            mul_req.a = {{(MUL_W-VW){1'b0}}, sdiff};
            mul_req.b = {{(MUL_W-VW){1'b0}}, sdiff};
        end
        else
        begin
            unique case (rstep_reg)
                2'd0:
                begin
                    mul_req.a = {{(MUL_W-CW){1'b0}}, rmag_x};
                    mul_req.b = {{(MUL_W-CW){1'b0}}, rmag_x};
                end
                2'd1:
                begin
                    mul_req.a = {{(MUL_W-VW){1'b0}}, dval};
                    mul_req.b = {{(MUL_W-VW){1'b0}}, dval};
                end
                2'd2:
                begin
                    mul_req.a = {{(MUL_W-VW){1'b0}}, t1_reg};
                    mul_req.b = HUNDRED_Q24;
                end
                default:
                begin
                    mul_req.a = {{(MUL_W-EW){1'b0}}, om_mag};
                    mul_req.b = {{(MUL_W-EW){1'b0}}, om_mag};
                end
            endcase
        end
    end

    nmr_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        loaded_next = loaded_reg;
        pass_next   = pass_reg;
        vidx_next   = vidx_reg;
        sidx_next   = sidx_reg;
        sp_next     = sp_reg;
        rstep_next  = rstep_reg;
        k_next      = k_reg;
        fin_next    = fin_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tlast)
                    begin
                        loaded_next = '0;
                        pass_next   = ITER_W'(1);
                        vidx_next   = '0;
                        fin_next    = 1'b0;
                        state_next  = ST_EVAL;
                    end
                    else if (loaded_reg < 2'd2)
                    begin
                        loaded_next = loaded_reg + 2'd1;
                    end
                end
            end
            ST_EVAL:
            begin
                ret_next   = ST_EVAL_DONE;
                rstep_next = '0;
                state_next = ST_ROS_ISSUE;
            end
            ST_ROS_ISSUE:
            begin
                state_next = ST_ROS_WAIT;
            end
            ST_ROS_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    if (rstep_reg == 2'd3)
                    begin
                        state_next = ret_reg;
                    end
                    else
                    begin
                        rstep_next = rstep_reg + 2'd1;
                        state_next = ST_ROS_ISSUE;
                    end
                end
            end
            ST_EVAL_DONE:
            begin
                if (vidx_reg == 2'd2)
                begin
                    if (fin_reg)
                    begin
                        k_next     = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        sidx_next  = '0;
                        state_next = ST_SORT;
                    end
                end
                else
                begin
                    vidx_next  = vidx_reg + 2'd1;
                    state_next = ST_EVAL;
                end
            end
            ST_SORT:
            begin
                if (sidx_reg == 2'd2)
                begin
                    sp_next    = '0;
                    state_next = ST_SPR_ISSUE;
                end
                else
                begin
                    sidx_next = sidx_reg + 2'd1;
                end
            end
            ST_SPR_ISSUE:
            begin
                state_next = ST_SPR_WAIT;
            end
            ST_SPR_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    if (sp_reg == 2'd2)
                    begin
                        state_next = ST_CENT;
                    end
                    else
                    begin
                        sp_next    = sp_reg + 2'd1;
                        state_next = ST_SPR_ISSUE;
                    end
                end
            end
            ST_CENT:
            begin
                state_next = ST_REFL;
            end
            ST_REFL:
            begin
                ret_next   = ST_REFL_DONE;
                rstep_next = '0;
                state_next = ST_ROS_ISSUE;
            end
            ST_REFL_DONE:
            begin
                if (rres_reg < v_reg[0])
                begin
                    ret_next   = ST_EXP_DONE;
                    rstep_next = '0;
                    state_next = ST_ROS_ISSUE;
                end
                else if (rres_reg >= v_reg[1])
                begin
                    state_next = ST_CONTR;
                end
                else
                begin
                    state_next = ST_PASS_END;
                end
            end
            ST_EXP_DONE:
            begin
                state_next = ST_PASS_END;
            end
            ST_CONTR:
            begin
                ret_next   = ST_CONTR_DONE;
                rstep_next = '0;
                state_next = ST_ROS_ISSUE;
            end
            ST_CONTR_DONE:
            begin
                state_next = ST_PASS_END;
            end
            ST_PASS_END:
            begin
                vidx_next  = '0;
                state_next = ST_EVAL;
                if (settled || (pass_reg == cap))
                begin
                    fin_next = 1'b1;
                end
                else
                begin
                    pass_next = pass_reg + ITER_W'(1);
                end
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            loaded_reg     <= '0;
            pass_reg       <= '0;
            vidx_reg       <= '0;
            sidx_reg       <= '0;
            sp_reg         <= '0;
            rstep_reg      <= '0;
            k_reg          <= '0;
            fin_reg        <= 1'b0;
            max_iter_reg   <= MAX_ITER_RESET;
            spread_lim_reg <= SPREAD_LIM_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            loaded_reg <= loaded_next;
            pass_reg   <= pass_next;
            vidx_reg   <= vidx_next;
            sidx_reg   <= sidx_next;
            sp_reg     <= sp_next;
            rstep_reg  <= rstep_next;
            k_reg      <= k_next;
            fin_reg    <= fin_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_MAX_ITER:     max_iter_reg   <= cfg_wdata[ITER_W-1:0];
                    CFG_SPREAD_LIMIT: spread_lim_reg <= cfg_wdata[LIMIT_W-1:0];
                    default:          max_iter_reg   <= max_iter_reg;
                endcase
            end
        end
    end

    // vertex store and working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (loaded_reg)
                        2'd0:
                        begin
                            vx_reg[0] <= in_x;
                            vy_reg[0] <= in_y;
                        end
                        2'd1:
                        begin
                            vx_reg[1] <= in_x;
                            vy_reg[1] <= in_y;
                        end
                        default:
                        begin
                            vx_reg[2] <= in_x;
                            vy_reg[2] <= in_y;
                        end
                    endcase
                end
            end
            ST_EVAL:
            begin
                unique case (vidx_reg)
                    2'd0:
                    begin
                        rx_reg <= vx_reg[0];
                        ry_reg <= vy_reg[0];
                    end
                    2'd1:
                    begin
                        rx_reg <= vx_reg[1];
                        ry_reg <= vy_reg[1];
                    end
                    default:
                    begin
                        rx_reg <= vx_reg[2];
                        ry_reg <= vy_reg[2];
                    end
                endcase
            end
            ST_ROS_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    unique case (rstep_reg)
                        2'd0:    x2_reg   <= mq;
                        2'd1:    t1_reg   <= mq;
                        2'd2:    t1_reg   <= mq;
                        default: rres_reg <= rsum[VW] ? VMAX : rsum[VW-1:0];
                    endcase
                end
            end
            ST_EVAL_DONE:
            begin
                unique case (vidx_reg)
                    2'd0:    v_reg[0] <= rres_reg;
                    2'd1:    v_reg[1] <= rres_reg;
                    default: v_reg[2] <= rres_reg;
                endcase
            end
            ST_SORT:
            begin
                sum_reg <= '0;
                unique case (sidx_reg)
                    2'd0:
                    begin
                        if (v_reg[0] > v_reg[1])
                        begin
                            v_reg[0]  <= v_reg[1];
                            v_reg[1]  <= v_reg[0];
                            vx_reg[0] <= vx_reg[1];
                            vx_reg[1] <= vx_reg[0];
                            vy_reg[0] <= vy_reg[1];
                            vy_reg[1] <= vy_reg[0];
                        end
                    end
                    2'd1:
                    begin
                        if (v_reg[0] > v_reg[2])
                        begin
                            v_reg[0]  <= v_reg[2];
                            v_reg[2]  <= v_reg[0];
                            vx_reg[0] <= vx_reg[2];
                            vx_reg[2] <= vx_reg[0];
                            vy_reg[0] <= vy_reg[2];
                            vy_reg[2] <= vy_reg[0];
                        end
                    end
                    default:
                    begin
                        if (v_reg[1] > v_reg[2])
                        begin
                            v_reg[1]  <= v_reg[2];
                            v_reg[2]  <= v_reg[1];
                            vx_reg[1] <= vx_reg[2];
                            vx_reg[2] <= vx_reg[1];
                            vy_reg[1] <= vy_reg[2];
                            vy_reg[2] <= vy_reg[1];
                        end
                    end
                endcase
            end
            ST_SPR_ISSUE:
            begin
                dbig_reg <= dbig;
            end
            ST_SPR_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    sum_reg <= ssum[SQ_W] ? {SQ_W{1'b1}} : ssum[SQ_W-1:0];
                end
            end
            ST_CENT:
            begin
                cx_reg <= halfsum(vx_reg[0], vx_reg[1]);
                cy_reg <= halfsum(vy_reg[0], vy_reg[1]);
            end
            ST_REFL:
            begin
                sx_reg <= reflect(cx_reg, vx_reg[2]);
                sy_reg <= reflect(cy_reg, vy_reg[2]);
                rx_reg <= reflect(cx_reg, vx_reg[2]);
                ry_reg <= reflect(cy_reg, vy_reg[2]);
            end
            ST_REFL_DONE:
            begin
                ys_reg <= rres_reg;
                if (rres_reg < v_reg[0])
                begin
                    ex_reg <= reflect(sx_reg, cx_reg);
                    ey_reg <= reflect(sy_reg, cy_reg);
                    rx_reg <= reflect(sx_reg, cx_reg);
                    ry_reg <= reflect(sy_reg, cy_reg);
                end
                else if (rres_reg >= v_reg[1])
                begin
                    if (rres_reg < v_reg[2])
                    begin
                        vx_reg[2] <= sx_reg;
                        vy_reg[2] <= sy_reg;
                    end
                end
                else
                begin
                    vx_reg[2] <= sx_reg;
                    vy_reg[2] <= sy_reg;
                end
            end
            ST_EXP_DONE:
            begin
                vx_reg[2] <= (rres_reg < ys_reg) ? ex_reg : sx_reg;
                vy_reg[2] <= (rres_reg < ys_reg) ? ey_reg : sy_reg;
            end
            ST_CONTR:
            begin
                ex_reg <= halfsum(vx_reg[2], cx_reg);
                ey_reg <= halfsum(vy_reg[2], cy_reg);
                rx_reg <= halfsum(vx_reg[2], cx_reg);
                ry_reg <= halfsum(vy_reg[2], cy_reg);
            end
            ST_CONTR_DONE:
            begin
                if (rres_reg < v_reg[2])
                begin
                    vx_reg[2] <= ex_reg;
                    vy_reg[2] <= ey_reg;
                end
                else
                begin
                    // shrink toward the best vertex
                    vx_reg[1] <= halfsum(vx_reg[1], vx_reg[0]);
                    vy_reg[1] <= halfsum(vy_reg[1], vy_reg[0]);
                    vx_reg[2] <= halfsum(vx_reg[2], vx_reg[0]);
                    vy_reg[2] <= halfsum(vy_reg[2], vy_reg[0]);
                end
            end
            default:
            begin
                rres_reg <= rres_reg;
            end
        endcase
    end

    // result request
    always_comb
    begin
        unique case (k_reg)
            2'd0:
            begin
                o_x = vx_reg[0];
                o_y = vy_reg[0];
                o_v = v_reg[0];
            end
            2'd1:
            begin
                o_x = vx_reg[1];
                o_y = vy_reg[1];
                o_v = v_reg[1];
            end
            default:
            begin
                o_x = vx_reg[2];
                o_y = vy_reg[2];
                o_v = v_reg[2];
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tlast  = (k_reg == 2'd2);
    assign m_axis_tdata  = OUT_W'({pass_reg, o_v, o_y, o_x});

    `NMR_ASSERT_IMP(a_no_input_while_out, m_axis_tvalid, !s_axis_tready,
                    "vertex accepted while results are pending")
    `NMR_ASSERT_IMP(a_mul_start_idle, mul_req.start, !mul_rsp.busy,
                    "multiplier restarted while busy")
    `NMR_ASSERT_IMP(a_pass_range, m_axis_tvalid, (pass_reg != '0) && (pass_reg <= cap),
                    "pass count out of range on result")
    `NMR_ASSERT_NXT(a_search_starts, in_acc && s_axis_tlast, !s_axis_tready,
                    "search did not start after marked vertex")
    `NMR_ASSERT_IMP(a_loaded_range, 1'b1, loaded_reg != 2'd3,
                    "vertex fill count out of range")

endmodule

FILE: src/nmr_mul.sv
// Shared 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on nmr_pkg.
module nmr_mul
    import nmr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [MUL_W-1:0]  a_reg;
    logic [MUL_W-1:0]  b_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [MUL_W-1:0]  pp_reg;
    logic [1:0]        psh_reg;
    logic              pv_reg;
    logic [2:0]        cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [HALF_W-1:0] opa;
    logic [HALF_W-1:0] opb;
    logic [1:0]        sh;
    logic [PROD_W-1:0] pp_shifted;

    // Pick the partial product for this step
    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:
            begin
                opa = a_reg[HALF_W-1:0];
                opb = b_reg[HALF_W-1:0];
                sh  = 2'd0;
            end
            2'd1:
            begin
                opa = a_reg[HALF_W-1:0];
                opb = b_reg[MUL_W-1:HALF_W];
                sh  = 2'd1;
            end
            2'd2:
            begin
                opa = a_reg[MUL_W-1:HALF_W];
                opb = b_reg[HALF_W-1:0];
                sh  = 2'd1;
            end
            default:
            begin
                opa = a_reg[MUL_W-1:HALF_W];
                opb = b_reg[MUL_W-1:HALF_W];
                sh  = 2'd2;
            end
        endcase
    end

    // Align the registered partial product
    always_comb
    begin
        unique case (psh_reg)
            2'd0:    pp_shifted = {{MUL_W{1'b0}}, pp_reg};
            2'd1:    pp_shifted = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default: pp_shifted = {pp_reg, {MUL_W{1'b0}}};
        endcase
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == 3'd4);
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                pv_reg  <= 1'b0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == 3'd4)
                begin
                    run_reg <= 1'b0;
                    pv_reg  <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    pv_reg  <= 1'b1;
                end
            end
        end
    end

    // Operands, partial product and accumulator
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else
        begin
            if (run_reg && (cnt_reg != 3'd4))
            begin
                pp_reg  <= opa * opb;
                psh_reg <= sh;
            end
            if (pv_reg)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign rsp.busy = run_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the 2D simplex search on the Rosenbrock function.
// Depends on nmr_pkg and nelder_mead_rosenbrock_2d; predicts every result vertex
// in fixed point and checks the result stream against that prediction.
module testbench;
    import nmr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW    = COORD_WIDTH_DEF;
    localparam int VW    = VALUE_WIDTH_DEF;
    localparam int IN_W  = ((2 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CW + VW + ITER_W + 7) / 8) * 8;
    localparam logic [63:0] VMAX = {1'b0, {63{1'b1}}};
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;
    localparam longint ONE_Q = 64'sd1 << FRAC;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct
    {
        logic [CW-1:0]     x;
        logic [CW-1:0]     y;
        logic [VW-1:0]     value;
        logic [ITER_W-1:0] passes;
        logic              last;
    } vertex_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;   // coord_x, coord_y
    logic                  s_axis_tlast;   // last_vertex
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;   // out_x, out_y, out_value, passes_done
    logic                  m_axis_tlast;   // last_result

    // predictor state and configuration
    longint            simplex_x [3];
    longint            simplex_y [3];
    logic [ITER_W-1:0] pass_cap;
    logic [31:0]       stop_spread;
    int                held_count;

    vertex_result_t expected_vertices[$];
    int  errors;
    int  searches_sent;
    int  results_seen;
    bit  idle_on;
    int  hold_requests;
    int  hold_served;
    int  hold_left;
    int  stall_left;

    nelder_mead_rosenbrock_2d DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ---------------- fixed-point predictor ----------------

    function automatic logic [63:0] mag(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, VMAX}) ? VMAX : s[63:0];
    endfunction

    // (a*b) >> 24, saturated
    function automatic logic [63:0] mul_q24(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:88] != 0)
            return VMAX;
        return (p[87:24] > VMAX) ? VMAX : p[87:24];
    endfunction

    function automatic longint clamp_coord(longint v);
        return (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
    endfunction

    function automatic longint mid_floor(longint a, longint b);
        return (a + b) >>> 1;
    endfunction

    function automatic logic [63:0] rosenbrock(longint x, longint y);
        logic [63:0] x2, d, t1, t2;
        x2 = mul_q24(mag(x), mag(x));
        if (y >= 0 && 64'(y) >= x2)
            d = 64'(y) - x2;
        else if (y >= 0)
            d = x2 - 64'(y);
        else
            d = sat_add(x2, mag(y));
        t1 = mul_q24(d, d);
        t1 = (t1 > VMAX / 100) ? VMAX : t1 * 100;
        t2 = mul_q24(mag(ONE_Q - x), mag(ONE_Q - x));
        return sat_add(t1, t2);
    endfunction

    function automatic logic [63:0] sq_gap(logic [63:0] hi, logic [63:0] lo);
        logic [63:0] d;
        d = hi - lo;
        return (d > 64'hFFFF_FFFF) ? '1 : d * d;
    endfunction

    function automatic bit spread_settled(logic [63:0] v [3]);
        logic [64:0] s;
        s = {1'b0, sq_gap(v[1], v[0])} + {1'b0, sq_gap(v[2], v[1])};
        if (s[64])
            s = {1'b0, {64{1'b1}}};
        s = {1'b0, s[63:0]} + {1'b0, sq_gap(v[2], v[0])};
        if (s[64])
            s = {1'b0, {64{1'b1}}};
        return (s[63:0] / 6) <= {32'd0, stop_spread};
    endfunction

    // Run one whole search on the predictor's simplex and queue its three vertices
    task automatic predict_search();
        int          cap;
        int          passes;
        logic [63:0] v [3];
        logic [63:0] tv, ys, ye;
        longint      tx, ty, cx, cy, sx, sy, ex, ey;
        vertex_result_t r;
        cap = (pass_cap == 0) ? 1 : int'(pass_cap);
        passes = 0;
        for (int p = 1; p <= cap; p++)
        begin
            for (int i = 0; i < 3; i++)
                v[i] = rosenbrock(simplex_x[i], simplex_y[i]);
            // order best first; swap only when strictly greater
            for (int i = 0; i < 2; i++)
                for (int j = i + 1; j < 3; j++)
                    if (v[i] > v[j])
                    begin
                        tv = v[i]; tx = simplex_x[i]; ty = simplex_y[i];
                        v[i] = v[j]; simplex_x[i] = simplex_x[j]; simplex_y[i] = simplex_y[j];
                        v[j] = tv; simplex_x[j] = tx; simplex_y[j] = ty;
                    end
            cx = mid_floor(simplex_x[0], simplex_x[1]);
            cy = mid_floor(simplex_y[0], simplex_y[1]);
            sx = clamp_coord(2 * cx - simplex_x[2]);
            sy = clamp_coord(2 * cy - simplex_y[2]);
            ys = rosenbrock(sx, sy);
            if (ys < v[0])
            begin
                // expand
                ex = clamp_coord(2 * sx - cx);
                ey = clamp_coord(2 * sy - cy);
                ye = rosenbrock(ex, ey);
                simplex_x[2] = (ye < ys) ? ex : sx;
                simplex_y[2] = (ye < ys) ? ey : sy;
            end
            else if (ys >= v[1])
            begin
                // contract, compared with the old worst value
                if (ys < v[2])
                begin
                    simplex_x[2] = sx;
                    simplex_y[2] = sy;
                end
                ex = mid_floor(simplex_x[2], cx);
                ey = mid_floor(simplex_y[2], cy);
                ye = rosenbrock(ex, ey);
                if (ye < v[2])
                begin
                    simplex_x[2] = ex;
                    simplex_y[2] = ey;
                end
                else
                begin
                    // shrink toward the best vertex
                    for (int i = 1; i < 3; i++)
                    begin
                        simplex_x[i] = mid_floor(simplex_x[i], simplex_x[0]);
                        simplex_y[i] = mid_floor(simplex_y[i], simplex_y[0]);
                    end
                end
            end
            else
            begin
                simplex_x[2] = sx;
                simplex_y[2] = sy;
            end
            passes = p;
            if (spread_settled(v))
                break;
        end
        for (int k = 0; k < 3; k++)
        begin
            r.x      = simplex_x[k][CW-1:0];
            r.y      = simplex_y[k][CW-1:0];
            r.value  = VW'(rosenbrock(simplex_x[k], simplex_y[k]) & VMAX);
            r.passes = passes[ITER_W-1:0];
            r.last   = (k == 2);
            expected_vertices.push_back(r);
        end
    endtask

    task automatic predict_vertex(logic [CW-1:0] x, logic [CW-1:0] y, bit mark);
        int slot;
        slot = (held_count > 2) ? 2 : held_count;
        simplex_x[slot] = longint'($signed(x));
        simplex_y[slot] = longint'($signed(y));
        if (!mark)
        begin
            if (held_count < 2)
                held_count++;
        end
        else
        begin
            predict_search();
            held_count = 0;
            searches_sent++;
        end
    endtask

    // ---------------- drivers ----------------

    // Offer one vertex request; returns at its accepting edge with tvalid still high
    task automatic send_vertex(logic [CW-1:0] x, logic [CW-1:0] y, bit mark);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predict_vertex(x, y, mark);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= mark;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop the request, then wait until every expected vertex is out and the block settles
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_MAX_ITER)
            pass_cap = val[ITER_W-1:0];
        else
            stop_spread = val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_problem(logic [CW-1:0] x0, logic [CW-1:0] y0,
                                logic [CW-1:0] x1, logic [CW-1:0] y1,
                                logic [CW-1:0] x2, logic [CW-1:0] y2);
        send_vertex(x0, y0, 1'b0);
        send_vertex(x1, y1, 1'b0);
        send_vertex(x2, y2, 1'b1);
    endtask

    function automatic logic [CW-1:0] rand_coord(bit full);
        if (full)
            return $urandom();
        return $urandom_range(0, 32'h0600_0000) - 32'h0300_0000;
    endfunction

    // ---------------- result side ----------------

    // Random stalls, and a long hold-off whenever one is requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_served   <= 0;
            hold_left     <= 0;
            stall_left    <= 0;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            m_axis_tready <= 1'b0;
            hold_served   <= hold_requests;
            hold_left     <= HOLD_CYCLES;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                stall_left <= $urandom_range(1, 11);
        end
    end

    // Compare each accepted result with the oldest expected vertex
    always @(posedge clk)
    begin
        vertex_result_t e;
        logic [CW-1:0]     ax, ay;
        logic [VW-1:0]     av;
        logic [ITER_W-1:0] ap;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            ax = m_axis_tdata[CW-1:0];
            ay = m_axis_tdata[2*CW-1:CW];
            av = m_axis_tdata[2*CW+VW-1:2*CW];
            ap = m_axis_tdata[2*CW+VW+ITER_W-1:2*CW+VW];
            results_seen++;
            if (expected_vertices.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result x=%h y=%h value=%h passes=%0d",
                         $time, ax, ay, av, ap);
            end
            else
            begin
                e = expected_vertices.pop_front();
                if (ax !== e.x)
                begin
                    errors++;
                    $display("%0t: out_x expected %h actual %h", $time, e.x, ax);
                end
                if (ay !== e.y)
                begin
                    errors++;
                    $display("%0t: out_y expected %h actual %h", $time, e.y, ay);
                end
                if (av !== e.value)
                begin
                    errors++;
                    $display("%0t: out_value expected %h actual %h", $time, e.value, av);
                end
                if (ap !== e.passes)
                begin
                    errors++;
                    $display("%0t: passes_done expected %0d actual %0d",
                             $time, e.passes, ap);
                end
                if (m_axis_tlast !== e.last)
                begin
                    errors++;
                    $display("%0t: last_result expected %b actual %b",
                             $time, e.last, m_axis_tlast);
                end
            end
        end
    end

    // ---------------- tests ----------------

    // Long search at the reset settings from the classic starting simplex
    task automatic test_reset_defaults();
        send_problem(32'hFECC_CCCD, 32'h0100_0000, 32'hFF00_0000, 32'h0100_0000,
                     32'hFECC_CCCD, 32'h0133_3333);
        wait_idle();
    endtask

    // Field extremes, zero and full iteration caps, saturation
    task automatic test_extremes();
        write_reg(CFG_MAX_ITER, 32'd0);
        write_reg(CFG_SPREAD_LIMIT, 32'hFFFF_FFFF);
        send_problem(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     32'h0000_0000, 32'hFFFF_FFFF);
        wait_idle();
        write_reg(CFG_MAX_ITER, 32'd65535);
        // identical vertices give zero spread, so the first pass stops
        send_problem(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
                     32'h0100_0000, 32'h0100_0000);
        wait_idle();
        write_reg(CFG_MAX_ITER, 32'd6);
        write_reg(CFG_SPREAD_LIMIT, 32'd0);
        send_problem(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h5555_5555, 32'hAAAA_AAAA);
        send_problem(32'h0000_0000, 32'h0000_0000, 32'h0200_0000, 32'h0000_0000,
                     32'h0000_0000, 32'h0200_0000);
        wait_idle();
    endtask

    // Extra unmarked vertex overwrites the third entry; an early mark reuses held entries
    task automatic test_odd_framing();
        send_vertex(32'h0080_0000, 32'h0040_0000, 1'b0);
        send_vertex(32'hFF80_0000, 32'h0100_0000, 1'b0);
        send_vertex(32'h0300_0000, 32'hFD00_0000, 1'b0);
        send_vertex(32'h00C0_0000, 32'h0090_0000, 1'b0);
        send_vertex(32'h0020_0000, 32'h0010_0000, 1'b1);
        send_vertex(32'h0110_0000, 32'h0120_0000, 1'b1);
        send_vertex(32'hFFF0_0000, 32'h0000_1000, 1'b0);
        send_vertex(32'h0001_0000, 32'h0002_0000, 1'b1);
        wait_idle();
    endtask

    // Long receiver hold-off while problems keep arriving, then a sender pause
    task automatic test_backpressure();
        write_reg(CFG_MAX_ITER, 32'd3);
        hold_requests <= hold_requests + 1;
        for (int n = 0; n < 4; n++)
            send_problem(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                         rand_coord(0), rand_coord(0));
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_vertices.size() != 0)
            @(posedge clk);
        send_problem(rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                     rand_coord(0), rand_coord(0));
        wait_idle();
    endtask

    // Random problems over several settings, with some noise in the framing
    task automatic test_random(int problems);
        logic [31:0] lim;
        bit full;
        for (int n = 0; n < problems; n++)
        begin
            if (n % 6 == 0)
            begin
                wait_idle();
                case ($urandom_range(0, 3))
                    0: lim = 32'd0;
                    1: lim = $urandom_range(1, 32'h0010_0000);
                    2: lim = $urandom();
                    default: lim = 32'hFFFF_FFFF;
                endcase
                write_reg(CFG_MAX_ITER, $urandom_range(1, 25));
                write_reg(CFG_SPREAD_LIMIT, lim);
            end
            full = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0:
                begin
                    send_vertex(rand_coord(full), rand_coord(full), 1'b0);
                    send_vertex(rand_coord(full), rand_coord(full), 1'b0);
                    send_vertex(rand_coord(full), rand_coord(full), 1'b0);
                    send_vertex(rand_coord(full), rand_coord(full), 1'b1);
                end
                1:
                    send_vertex(rand_coord(full), rand_coord(full), 1'b1);
                default:
                    send_problem(rand_coord(full), rand_coord(full), rand_coord(full),
                                 rand_coord(full), rand_coord(full), rand_coord(full));
            endcase
        end
        wait_idle();
    endtask

    initial
    begin
        errors        = 0;
        searches_sent = 0;
        results_seen  = 0;
        idle_on       = 1'b1;
        hold_requests = 0;
        pass_cap      = MAX_ITER_RESET;
        stop_spread   = SPREAD_LIM_RESET;
        held_count    = 0;
        for (int i = 0; i < 3; i++)
        begin
            simplex_x[i] = 0;
            simplex_y[i] = 0;
        end
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_MAX_ITER;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        test_reset_defaults();
        test_extremes();
        test_odd_framing();
        test_backpressure();
        test_random(24);
        // last stretch with no idling on either side
        idle_on = 1'b0;
        test_random(6);

        repeat (200) @(posedge clk);
        $display("Ran %0d searches, %0d result vertices checked, across caps 0 to 65535",
                 searches_sent, results_seen);
        $display("and spread limits 0 to max, with framing noise, stalls and a long hold-off.");
        if (errors == 0 && expected_vertices.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Timeout with %0d vertices still expected", expected_vertices.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
